// ----- rtl/stbm_pkg.sv -----
// ----------------------------------------------------------------------------
// stbm_pkg
// Shared sizes, codes, memory request types and ranking helpers for the
// suffix trie best-match block.
// ----------------------------------------------------------------------------
package stbm_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int ALPHABET_SIZE = 26;

  localparam int SYM_W   = 5;
  localparam int IDX_W   = 14;
  localparam int LEN_W   = 12;
  localparam int OUT_W   = IDX_W + 1;
  localparam int STAT_W  = 2;
  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int FREE_W  = $clog2(NODE_COUNT + 1);
  localparam int BEST_W  = OUT_W + LEN_W;

  localparam int CHILD_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int SLOT_W      = $clog2(CHILD_DEPTH);

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [STAT_W-1:0] ST_ANSWER = 2'd0;
  localparam logic [STAT_W-1:0] ST_DONE   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

  localparam logic [OUT_W-1:0] EMPTY_INDEX = {OUT_W{1'b1}};

  typedef struct packed {
    logic              en;
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [NODE_W-1:0] wdata;
  } child_req_t;

  typedef struct packed {
    logic              en;
    logic              we;
    logic [NODE_W-1:0] addr;
    logic [BEST_W-1:0] wdata;
  } best_req_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [NODE_W-1:0] node,
                                                input logic [SYM_W-1:0]  sym);
    slot_of = SLOT_W'(node) * SLOT_W'(ALPHABET_SIZE) + SLOT_W'(sym);
  endfunction

  function automatic logic [BEST_W-1:0] best_pack(input logic [IDX_W-1:0] idx,
                                                  input logic [LEN_W-1:0] len);
    best_pack = {OUT_W'(idx), len};
  endfunction

  function automatic logic rank_take(input logic [BEST_W-1:0] old,
                                     input logic [IDX_W-1:0]  idx,
                                     input logic [LEN_W-1:0]  len);
    logic [OUT_W-1:0] old_idx;
    logic [LEN_W-1:0] old_len;
    old_idx   = old[BEST_W-1 -: OUT_W];
    old_len   = old[LEN_W-1:0];
    rank_take = old_idx[OUT_W-1] || (len < old_len) ||
                ((len == old_len) && (OUT_W'(idx) < old_idx));
  endfunction

endpackage

// ----- rtl/stbm_ram.sv -----
// ----------------------------------------------------------------------------
// stbm_ram
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module stbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- rtl/stbm_obuf.sv -----
// ----------------------------------------------------------------------------
// stbm_obuf
// Output register: holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module stbm_obuf (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  output logic                        res_ready,
  input  logic [stbm_pkg::OUT_W-1:0]  res_index,
  input  logic [stbm_pkg::STAT_W-1:0] res_status,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [stbm_pkg::OUT_W-1:0] best_index,
  output logic [stbm_pkg::STAT_W-1:0] status
);
  import stbm_pkg::*;

  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      best_index <= res_index;
      status     <= res_status;
    end
  end

endmodule

// ----- rtl/stbm_ctrl.sv -----
// ----------------------------------------------------------------------------
// stbm_ctrl
// Walk sequencer: clears the memories after reset, then per character reads
// the child link; on inserts it ranks the root and the node reached and
// allocates new nodes; it hands the final beat of a word to the output register.
// ----------------------------------------------------------------------------
module stbm_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [stbm_pkg::SYM_W-1:0]  symbol,
  input  logic                        first_char,
  input  logic                        last_char,
  input  logic [stbm_pkg::IDX_W-1:0]  word_index,
  input  logic [stbm_pkg::LEN_W-1:0]  word_length,
  output stbm_pkg::child_req_t        child_req,
  input  logic [stbm_pkg::NODE_W-1:0] child_rdata,
  output stbm_pkg::best_req_t         best_req,
  input  logic [stbm_pkg::BEST_W-1:0] best_rdata,
  output logic                        res_valid,
  input  logic                        res_ready,
  output logic [stbm_pkg::OUT_W-1:0]  res_index,
  output logic [stbm_pkg::STAT_W-1:0] res_status
);
  import stbm_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LINK  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_RANK  = 3'd4;
  localparam logic [2:0] S_ANS   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]        state, state_next;
  logic [SLOT_W-1:0] clr_cnt, clr_cnt_next;
  logic [NODE_W-1:0] cur, cur_next;
  logic [FREE_W-1:0] free_cnt, free_cnt_next;
  logic              stopped, stopped_next;
  logic              ovf, ovf_next;
  logic [OUT_W-1:0]  res_index_next;
  logic [STAT_W-1:0] res_status_next;

  logic              cmd_q;
  logic [SYM_W-1:0]  sym_q;
  logic              first_q;
  logic              last_q;
  logic [IDX_W-1:0]  idx_q;
  logic [LEN_W-1:0]  len_q;

  logic              accept;
  logic [NODE_W-1:0] cur_eff;
  logic              go_rank;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cur_eff  = first_char ? '0 : cur;

  always_comb begin
    state_next      = state;
    clr_cnt_next    = clr_cnt;
    cur_next        = cur;
    free_cnt_next   = free_cnt;
    stopped_next    = stopped;
    ovf_next        = ovf;
    res_index_next  = res_index;
    res_status_next = res_status;
    child_req       = '0;
    best_req        = '0;
    res_valid       = 1'b0;
    go_rank         = 1'b0;
    unique case (state)
      S_CLEAR: begin
        child_req.en    = 1'b1;
        child_req.we    = 1'b1;
        child_req.addr  = clr_cnt;
        child_req.wdata = '0;
        if (clr_cnt < SLOT_W'(NODE_COUNT)) begin
          best_req.en    = 1'b1;
          best_req.we    = 1'b1;
          best_req.addr  = clr_cnt[NODE_W-1:0];
          best_req.wdata = {EMPTY_INDEX, {LEN_W{1'b0}}};
        end
        clr_cnt_next = clr_cnt + 1'b1;
        if (clr_cnt == SLOT_W'(CHILD_DEPTH - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          cur_next = cur_eff;
          if (first_char) begin
            stopped_next = 1'b0;
            ovf_next     = 1'b0;
          end
          child_req.en   = 1'b1;
          child_req.addr = slot_of(cur_eff, symbol);
          if (first_char && command == CMD_INSERT) begin
            best_req.en   = 1'b1;
            best_req.addr = '0;
          end
          state_next = S_LINK;
        end
      end
      S_LINK: begin
        if (first_q && cmd_q == CMD_INSERT && rank_take(best_rdata, idx_q, len_q)) begin
          best_req.en    = 1'b1;
          best_req.we    = 1'b1;
          best_req.addr  = '0;
          best_req.wdata = best_pack(idx_q, len_q);
        end
        state_next = S_WALK;
      end
      S_WALK: begin
        if (!stopped) begin
          if (sym_q >= SYM_W'(ALPHABET_SIZE)) begin
            stopped_next = 1'b1;
          end else if (cmd_q == CMD_QUERY) begin
            if (child_rdata == '0) begin
              stopped_next = 1'b1;
            end else begin
              cur_next = child_rdata;
            end
          end else if (child_rdata == '0) begin
            if (free_cnt >= FREE_W'(NODE_COUNT)) begin
              ovf_next     = 1'b1;
              stopped_next = 1'b1;
            end else begin
              child_req.en    = 1'b1;
              child_req.we    = 1'b1;
              child_req.addr  = slot_of(cur, sym_q);
              child_req.wdata = free_cnt[NODE_W-1:0];
              best_req.en     = 1'b1;
              best_req.we     = 1'b1;
              best_req.addr   = free_cnt[NODE_W-1:0];
              best_req.wdata  = best_pack(idx_q, len_q);
              free_cnt_next   = free_cnt + 1'b1;
              cur_next        = free_cnt[NODE_W-1:0];
            end
          end else begin
            cur_next      = child_rdata;
            best_req.en   = 1'b1;
            best_req.addr = child_rdata;
            go_rank       = 1'b1;
          end
        end
        priority if (go_rank) begin
          state_next = S_RANK;
        end else if (!last_q) begin
          state_next = S_IDLE;
        end else if (cmd_q == CMD_QUERY) begin
          best_req.en   = 1'b1;
          best_req.addr = cur_next;
          state_next    = S_ANS;
        end else begin
          res_index_next  = '0;
          res_status_next = ovf_next ? ST_FULL : ST_DONE;
          state_next      = S_EMIT;
        end
      end
      S_RANK: begin
        if (rank_take(best_rdata, idx_q, len_q)) begin
          best_req.en    = 1'b1;
          best_req.we    = 1'b1;
          best_req.addr  = cur;
          best_req.wdata = best_pack(idx_q, len_q);
        end
        if (last_q) begin
          res_index_next  = '0;
          res_status_next = ovf ? ST_FULL : ST_DONE;
          state_next      = S_EMIT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_ANS: begin
        res_index_next  = best_rdata[BEST_W-1 -: OUT_W];
        res_status_next = ST_ANSWER;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      cur      <= '0;
      free_cnt <= FREE_W'(1);
      stopped  <= 1'b0;
      ovf      <= 1'b0;
    end else begin
      state    <= state_next;
      clr_cnt  <= clr_cnt_next;
      cur      <= cur_next;
      free_cnt <= free_cnt_next;
      stopped  <= stopped_next;
      ovf      <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    res_index  <= res_index_next;
    res_status <= res_status_next;
    if (accept) begin
      cmd_q   <= command;
      sym_q   <= symbol;
      first_q <= first_char;
      last_q  <= last_char;
      idx_q   <= word_index;
      len_q   <= word_length;
    end
  end

  a_cur_allocated: assert property (@(posedge clk) disable iff (rst)
    FREE_W'(cur) < free_cnt)
    else $error("current node lies beyond the allocated pool");

  a_free_in_range: assert property (@(posedge clk) disable iff (rst)
    (free_cnt != '0) && (free_cnt <= FREE_W'(NODE_COUNT)))
    else $error("free node count out of range");

  a_ovf_stops: assert property (@(posedge clk) disable iff (rst)
    ovf |-> stopped)
    else $error("pool overflow without a stopped walk");

  a_alloc_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK && child_req.we) |=> (free_cnt == $past(free_cnt) + 1'b1))
    else $error("node allocation did not advance the pool by one");

endmodule

// ----- rtl/suffix_trie_best_match.sv -----
// ----------------------------------------------------------------------------
// suffix_trie_best_match
// Suffix trie over a node pool with best-match ranking per node.
// ----------------------------------------------------------------------------
// After reset the block clears the node-best memory and all NODE_COUNT *
// ALPHABET_SIZE = 106496 child-link entries, one entry a cycle, with in_stall
// held high. It then takes one character beat at a time: a character passes
// S_IDLE, S_LINK and S_WALK, plus S_RANK when an insert reaches an existing
// node (a read-compare-write of the node's best entry), S_ANS when a query
// finishes a word (the read of the node's best entry), and S_EMIT on the last
// character of any word to hand the result beat to the output register, plus
// any wait for that register. The steps are set by the registered reads of the
// child-link RAM and the node-best RAM, each character needing the node found
// by the one before. A result beat comes out only on the last character of a
// word; the output register lets the next character enter while it waits.
// ----------------------------------------------------------------------------
module suffix_trie_best_match (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        command,
  input  logic [stbm_pkg::SYM_W-1:0]  symbol,
  input  logic                        first_char,
  input  logic                        last_char,
  input  logic [stbm_pkg::IDX_W-1:0]  word_index,
  input  logic [stbm_pkg::LEN_W-1:0]  word_length,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [stbm_pkg::OUT_W-1:0] best_index,
  output logic [stbm_pkg::STAT_W-1:0] status
);
  import stbm_pkg::*;

  child_req_t        child_req;
  best_req_t         best_req;
  logic [NODE_W-1:0] child_rdata;
  logic [BEST_W-1:0] best_rdata;
  logic              res_valid;
  logic              res_ready;
  logic [OUT_W-1:0]  res_index;
  logic [STAT_W-1:0] res_status;

  stbm_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .symbol      (symbol),
    .first_char  (first_char),
    .last_char   (last_char),
    .word_index  (word_index),
    .word_length (word_length),
    .child_req   (child_req),
    .child_rdata (child_rdata),
    .best_req    (best_req),
    .best_rdata  (best_rdata),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_index   (res_index),
    .res_status  (res_status)
  );

  stbm_ram #(
    .WIDTH (NODE_W),
    .DEPTH (CHILD_DEPTH)
  ) u_child_ram (
    .clk   (clk),
    .en    (child_req.en),
    .we    (child_req.we),
    .addr  (child_req.addr),
    .wdata (child_req.wdata),
    .rdata (child_rdata)
  );

  stbm_ram #(
    .WIDTH (BEST_W),
    .DEPTH (NODE_COUNT)
  ) u_best_ram (
    .clk   (clk),
    .en    (best_req.en),
    .we    (best_req.we),
    .addr  (best_req.addr),
    .wdata (best_req.wdata),
    .rdata (best_rdata)
  );

  stbm_obuf u_obuf (
    .clk        (clk),
    .rst        (rst),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_index  (res_index),
    .res_status (res_status),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .best_index (best_index),
    .status     (status)
  );

endmodule
